[sv/device_sighting_table_assert.svh]
// assertion macros for the device sighting table checker
`ifndef DEVICE_SIGHTING_TABLE_ASSERT_SVH
`define DEVICE_SIGHTING_TABLE_ASSERT_SVH

// same-cycle implication
`define DST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sta_pkg.sv]
// shared types, constants and widths of the device sighting table
package sta_pkg;

  localparam int STA_ENTRIES  = 16;
  localparam int AddrW        = 48;
  localparam int TimeW        = 32;
  localparam int LevelW       = 8;
  localparam int TierW        = 3;
  localparam int HoldW        = 16;
  localparam int SlotW        = 4;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 32;
  localparam int InDataW      = 128;
  localparam int OutDataW     = 48;

  localparam logic [HoldW-1:0] HOLDOFF_RST = HoldW'(10000);
  localparam logic [TimeW-1:0] WINDOW_RST  = TimeW'(30000);
  localparam logic [TierW-1:0] STRONG_RST  = TierW'(2);

  localparam logic [CfgIdxW-1:0] CFG_HOLDOFF = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STRONG  = 2'd2;

  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOG,
    S_UPD,
    S_REC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              ble;
    logic [AddrW-1:0]  addr;
    logic [TimeW-1:0]  seen;
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  count;
    logic [TierW-1:0]  tier;
    logic              aclass;
    logic              log_valid;
    logic [TimeW-1:0]  logged;
  } row_t;

  typedef struct packed {
    logic              mode;
    logic [AddrW-1:0]  addr;
    logic              is_ble;
    logic [TimeW-1:0]  stamp;
    logic [TimeW-1:0]  now;
    logic [LevelW-1:0] level;
    logic [TierW-1:0]  tier;
    logic              aclass;
    logic              muted;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0] diff;
    logic             gt;
    logic             ge;
    logic             le;
  } alu_res_t;

endpackage

[sv/sta_ram.sv]
// generic single-write, single-read memory with registered read data
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/sta_alu.sv]
// shared modular subtract and compare unit
module sta_alu
  import sta_pkg::*;
(
  input  logic [TimeW-1:0] a,
  input  logic [TimeW-1:0] b,
  input  logic [TimeW-1:0] lim,
  output alu_res_t         res
);

  logic [TimeW-1:0] diff;

  assign diff     = a - b;
  assign res.diff = diff;
  assign res.gt   = diff > lim;
  assign res.ge   = diff >= lim;
  assign res.le   = diff <= lim;

endmodule

[sv/device_sighting_table.sv]
// Device sighting table top level. An observe beat steps through S_SCAN,
// S_LOG, S_UPD, S_REC and S_OUT; the scan stops at a hit and otherwise walks
// every entry, and the next beat is taken only once the result has moved to
// the output register. The row memory has one read port and the
// search walks it one entry per cycle, with one subtract-and-compare unit
// shared by the age search, the log holdoff check and the recent-alert check.
// A clear beat goes from S_IDLE straight to S_OUT and skips the search.
// in_tready is high only while no beat is in work. A finished result waits in
// the output register and the next beat is taken meanwhile; a stalled output
// closes the input only once a second result is waiting. Configuration writes
// are expected only while the block is idle.
module device_sighting_table
  import sta_pkg::*;
#(
  parameter int ENTRIES = STA_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // device_address, is_ble, stamp_ms, now_ms, signal_level, match_tier,
  // alert_class, muted, zero fill
  input  logic [InDataW-1:0]  in_tdata,
  // mode
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // slot, hit, sight_count, kept_tier, new_evidence, log_event, alert,
  // recent_alert, zero fill
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [HoldW-1:0]   holdoff_r;
  logic [TimeW-1:0]   window_r;
  logic [TierW-1:0]   strong_r;

  item_t              item_r, item_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               strong_valid_r, strong_valid_nxt;
  logic [TimeW-1:0]   last_strong_r, last_strong_nxt;

  logic [IW-1:0]      issue_r, issue_nxt;
  logic               issue_last_r, issue_last_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic [IW-1:0]      chk_idx_r, chk_idx_nxt;
  logic               free_v_r, free_v_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [TimeW-1:0]   best_age_r, best_age_nxt;
  logic               hit_r, hit_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  row_t               row_r, row_nxt;
  logic               log_ok_r, log_ok_nxt;

  logic [TimeW-1:0]   res_count_r, res_count_nxt;
  logic [TierW-1:0]   res_tier_r, res_tier_nxt;
  logic               res_newev_r, res_newev_nxt;
  logic               res_log_r, res_log_nxt;
  logic               res_alert_r, res_alert_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [SlotW-1:0]   res_slot_r, res_slot_nxt;
  logic               res_recent_r, res_recent_nxt;

  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OutDataW-1:0] out_tdata_r, out_tdata_nxt;

  logic               ram_we;
  row_t               ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [$bits(row_t)-1:0] ram_rdata_raw;
  row_t               ram_rdata;

  logic [TimeW-1:0]   alu_a, alu_b, alu_lim;
  alu_res_t           alu_res;

  logic               ent_valid, ent_match;
  logic               newev, logev, strong_hit;
  row_t               upd_row;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign ram_rdata  = row_t'(ram_rdata_raw);

  sta_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  sta_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .lim (alu_lim),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= HOLDOFF_RST;
      window_r  <= WINDOW_RST;
      strong_r  <= STRONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HOLDOFF: holdoff_r <= cfg_wdata[HoldW-1:0];
        CFG_WINDOW:  window_r  <= cfg_wdata[TimeW-1:0];
        CFG_STRONG:  strong_r  <= cfg_wdata[TierW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      valid_r        <= '0;
      strong_valid_r <= 1'b0;
      out_tvalid_r   <= 1'b0;
      issue_last_r   <= 1'b0;
      chk_v_r        <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      valid_r        <= valid_nxt;
      strong_valid_r <= strong_valid_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
      issue_last_r   <= issue_last_nxt;
      chk_v_r        <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    last_strong_r <= last_strong_nxt;
    issue_r       <= issue_nxt;
    chk_idx_r     <= chk_idx_nxt;
    free_v_r      <= free_v_nxt;
    free_idx_r    <= free_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_age_r    <= best_age_nxt;
    hit_r         <= hit_nxt;
    slot_r        <= slot_nxt;
    row_r         <= row_nxt;
    log_ok_r      <= log_ok_nxt;
    res_count_r   <= res_count_nxt;
    res_tier_r    <= res_tier_nxt;
    res_newev_r   <= res_newev_nxt;
    res_log_r     <= res_log_nxt;
    res_alert_r   <= res_alert_nxt;
    res_hit_r     <= res_hit_nxt;
    res_slot_r    <= res_slot_nxt;
    res_recent_r  <= res_recent_nxt;
    out_tdata_r   <= out_tdata_nxt;
  end

  // entry under check and row update
  assign ent_valid  = valid_r[chk_idx_r];
  assign ent_match  = ent_valid && (ram_rdata.ble == item_r.is_ble) &&
                      (ram_rdata.addr == item_r.addr);
  assign newev      = item_r.tier > row_r.tier;
  assign logev      = (item_r.tier != '0) && (newev || !row_r.log_valid || log_ok_r);
  assign strong_hit = item_r.aclass && (item_r.tier >= strong_r);

  always_comb begin
    upd_row       = row_r;
    upd_row.seen  = item_r.stamp;
    upd_row.level = item_r.level;
    upd_row.count = row_r.count + TimeW'(1);
    if (item_r.tier >= row_r.tier) begin
      upd_row.tier   = item_r.tier;
      upd_row.aclass = item_r.aclass;
    end
    if (logev) begin
      upd_row.log_valid = 1'b1;
      upd_row.logged    = item_r.stamp;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    item_nxt         = item_r;
    valid_nxt        = valid_r;
    strong_valid_nxt = strong_valid_r;
    last_strong_nxt  = last_strong_r;
    issue_nxt        = issue_r;
    issue_last_nxt   = issue_last_r;
    chk_v_nxt        = 1'b0;
    chk_idx_nxt      = chk_idx_r;
    free_v_nxt       = free_v_r;
    free_idx_nxt     = free_idx_r;
    best_idx_nxt     = best_idx_r;
    best_age_nxt     = best_age_r;
    hit_nxt          = hit_r;
    slot_nxt         = slot_r;
    row_nxt          = row_r;
    log_ok_nxt       = log_ok_r;
    res_count_nxt    = res_count_r;
    res_tier_nxt     = res_tier_r;
    res_newev_nxt    = res_newev_r;
    res_log_nxt      = res_log_r;
    res_alert_nxt    = res_alert_r;
    res_hit_nxt      = res_hit_r;
    res_slot_nxt     = res_slot_r;
    res_recent_nxt   = res_recent_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_tdata_nxt    = out_tdata_r;
    ram_we           = 1'b0;
    ram_wdata        = upd_row;
    ram_re           = 1'b0;
    ram_raddr        = issue_r;
    alu_a            = item_r.now;
    alu_b            = ram_rdata.seen;
    alu_lim          = best_age_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          item_nxt.mode   = in_tuser;
          item_nxt.addr   = in_tdata[47:0];
          item_nxt.is_ble = in_tdata[48];
          item_nxt.stamp  = in_tdata[80:49];
          item_nxt.now    = in_tdata[112:81];
          item_nxt.level  = in_tdata[120:113];
          item_nxt.tier   = in_tdata[123:121];
          item_nxt.aclass = in_tdata[124];
          item_nxt.muted  = in_tdata[125];
          issue_nxt       = '0;
          issue_last_nxt  = 1'b0;
          free_v_nxt      = 1'b0;
          best_idx_nxt    = '0;
          best_age_nxt    = '0;
          if (in_tuser == MODE_CLEAR) begin
            valid_nxt        = '0;
            strong_valid_nxt = 1'b0;
            res_count_nxt    = '0;
            res_tier_nxt     = '0;
            res_newev_nxt    = 1'b0;
            res_log_nxt      = 1'b0;
            res_alert_nxt    = 1'b0;
            res_hit_nxt      = 1'b0;
            res_slot_nxt     = '0;
            res_recent_nxt   = 1'b0;
            state_nxt        = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        ram_re = !issue_last_r;
        if (!issue_last_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = issue_r;
          if (issue_r == LastIdx) begin
            issue_last_nxt = 1'b1;
          end else begin
            issue_nxt = issue_r + IW'(1);
          end
        end
        if (chk_v_r) begin
          if (ent_match) begin
            hit_nxt   = 1'b1;
            slot_nxt  = chk_idx_r;
            row_nxt   = ram_rdata;
            state_nxt = S_LOG;
          end else begin
            if (!ent_valid) begin
              if (!free_v_r) begin
                free_v_nxt   = 1'b1;
                free_idx_nxt = chk_idx_r;
              end
            end else if ((chk_idx_r == '0) || alu_res.gt) begin
              best_idx_nxt = chk_idx_r;
              best_age_nxt = alu_res.diff;
            end
            if (chk_idx_r == LastIdx) begin
              hit_nxt      = 1'b0;
              slot_nxt     = free_v_nxt ? free_idx_nxt : best_idx_nxt;
              row_nxt      = '0;
              row_nxt.ble  = item_r.is_ble;
              row_nxt.addr = item_r.addr;
              state_nxt    = S_LOG;
            end
          end
        end
      end

      S_LOG: begin
        alu_a      = item_r.stamp;
        alu_b      = row_r.logged;
        alu_lim    = TimeW'(holdoff_r);
        log_ok_nxt = alu_res.ge;
        state_nxt  = S_UPD;
      end

      S_UPD: begin
        ram_we             = 1'b1;
        valid_nxt[slot_r]  = 1'b1;
        if (strong_hit) begin
          strong_valid_nxt = 1'b1;
          last_strong_nxt  = item_r.stamp;
        end
        res_count_nxt = upd_row.count;
        res_tier_nxt  = upd_row.tier;
        res_newev_nxt = newev;
        res_log_nxt   = logev;
        res_alert_nxt = logev && newev && (item_r.tier >= strong_r) && !item_r.muted;
        res_hit_nxt   = hit_r;
        res_slot_nxt  = SlotW'(slot_r);
        state_nxt     = S_REC;
      end

      S_REC: begin
        alu_a          = item_r.now;
        alu_b          = last_strong_r;
        alu_lim        = window_r;
        res_recent_nxt = strong_valid_r && alu_res.le;
        state_nxt      = S_OUT;
      end

      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OutDataW'({res_recent_r, res_alert_r, res_log_r, res_newev_r,
                                      res_tier_r, res_count_r, res_hit_r, res_slot_r});
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/device_sighting_table_chk.sv]
// port-level checker for the device sighting table and its bind
`include "device_sighting_table_assert.svh"

module device_sighting_table_chk
  import sta_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // the input is closed in the cycle after a beat is accepted
  `DST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // alert only comes with a log event and new evidence
  `DST_ASSERT_NOW(a_alert_needs_log, clk, rst_n, out_tvalid && out_tdata[42], out_tdata[41] && out_tdata[40], "alert without log event or new evidence")

  // new evidence leaves a nonzero kept tier
  `DST_ASSERT_NOW(a_newev_tier, clk, rst_n, out_tvalid && out_tdata[40], out_tdata[39:37] != 3'd0, "new evidence with zero kept tier")

  // a stalled result holds
  `DST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind device_sighting_table device_sighting_table_chk u_chk (.*);
